[sv/rkmtf_pkg.sv]
// Package for the recent-key move-to-front ring.
// Holds sizes, request/result structs and the slot store port struct.
// No dependencies.
`default_nettype none

package rkmtf_pkg;

  // ring geometry
  localparam int unsigned DEPTH    = 16;
  localparam int unsigned KEY_BITS = 64;
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = IDX_W + 1;

  // field widths of the request and result
  localparam int unsigned KEY_FIELD_W = 64;
  localparam int unsigned AGE_W       = 4;

  typedef logic [IDX_W-1:0]    slot_t;
  typedef logic [KEY_BITS-1:0] key_t;

  // one request
  typedef struct packed {
    logic                   kind;
    logic [KEY_FIELD_W-1:0] key;
    logic [AGE_W-1:0]       age_index;
  } req_t;

  // one result
  typedef struct packed {
    logic [KEY_FIELD_W-1:0] entry_key;
    logic                   occupied;
    logic                   hit;
  } res_t;

  // access to the slot store
  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    logic  wr_en;
    slot_t wr_addr;
    key_t  wr_data;
  } store_req_t;

  // request kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // step to the next slot of the ring
  function automatic slot_t ring_next(input slot_t s);
    slot_t r;
    if (s == slot_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/rkmtf_slot_store.sv]
// Slot store of the recent-key ring: one synchronous memory with
// one read and one write port, plus a valid bit per slot for reset.
// Depends on rkmtf_pkg.
`default_nettype none

module rkmtf_slot_store
  import rkmtf_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  store_req_t acc_i,
  output key_t       rd_data_o
);

  key_t             mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  key_t             rdata_q;
  logic             rvalid_q;

  // memory array, registered read
  always_ff @(posedge clk_i) begin
    if (acc_i.wr_en) begin
      mem_q[acc_i.wr_addr] <= acc_i.wr_data;
    end
    if (acc_i.rd_en) begin
      rdata_q <= mem_q[acc_i.rd_addr];
    end
  end

  // valid bits, cleared at reset so every slot reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (acc_i.wr_en) begin
        valid_q[acc_i.wr_addr] <= 1'b1;
      end
      if (acc_i.rd_en) begin
        rvalid_q <= valid_q[acc_i.rd_addr];
      end
    end
  end

  // a slot never written reads as the empty key
  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

[sv/recent_key_move_to_front_ring_top.sv]
// Recent-key move-to-front ring: a read request returns the entry of the given age.
// An add runs a pipelined search, oldest first; on a hit the newer entries then shift back
// one slot and the key moves to the newest slot, on a miss the key overwrites the oldest slot.
// One request at a time; busy drops as done_o rises, so the next request may be taken then.
// The receiver cannot stall: each result stands on res_o for one cycle with done_o.
// Reset clears the head and the per-slot valid bits at once; no clearing pass.
`default_nettype none

module recent_key_move_to_front_ring_top
  import rkmtf_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RD_ISSUE = 3'd1;
  localparam logic [2:0] ST_RD_WAIT  = 3'd2;
  localparam logic [2:0] ST_SEARCH   = 3'd3;
  localparam logic [2:0] ST_SHIFT    = 3'd4;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [2:0]       state_q, state_d;
  slot_t            head_q, head_d;
  logic             kind_q, kind_d;
  key_t             key_q, key_d;
  logic [AGE_W-1:0] age_q, age_d;
  logic [CNT_W-1:0] scnt_q, scnt_d;
  slot_t            rptr_q, rptr_d;
  logic             cmp_v_q, cmp_v_d;
  slot_t            cmp_ptr_q, cmp_ptr_d;
  slot_t            prev_q, prev_d;
  slot_t            cur_q, cur_d;
  slot_t            wprev_q, wprev_d;
  logic             pend_q, pend_d;
  logic             done_q, done_d;
  res_t             res_q, res_d;

  store_req_t acc;
  key_t       rd_data;
  logic       match;
  logic       age_ok;
  logic [31:0] sum_raw;
  logic [31:0] sum_wrap;
  slot_t      rd_slot;

  rkmtf_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .rd_data_o (rd_data)
  );

  // slot of a read by age: head - 1 - age, wrapped once
  always_comb begin
    age_ok   = 32'(age_q) < 32'(DEPTH);
    sum_raw  = 32'(head_q) + 32'(DEPTH) - 32'd1 - 32'(age_q);
    sum_wrap = (sum_raw >= 32'(DEPTH)) ? (sum_raw - 32'(DEPTH)) : sum_raw;
    rd_slot  = sum_wrap[IDX_W-1:0];
  end

  // search hit on the entry that came back from the store
  assign match = cmp_v_q && (rd_data != '0) && (rd_data == key_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    kind_d    = kind_q;
    key_d     = key_q;
    age_d     = age_q;
    scnt_d    = scnt_q;
    rptr_d    = rptr_q;
    cmp_v_d   = 1'b0;
    cmp_ptr_d = cmp_ptr_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    wprev_d   = wprev_q;
    pend_d    = pend_q;
    done_d    = 1'b0;
    res_d     = res_q;
    acc       = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d = req_i.kind;
          key_d  = req_i.key[KEY_BITS-1:0];
          age_d  = req_i.age_index;
          scnt_d = '0;
          rptr_d = head_q;
          if (req_i.kind == KIND_READ) begin
            state_d = ST_RD_ISSUE;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end

      ST_RD_ISSUE: begin
        if (age_ok) begin
          acc.rd_en   = 1'b1;
          acc.rd_addr = rd_slot;
          state_d     = ST_RD_WAIT;
        end else begin
          res_d   = '0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_RD_WAIT: begin
        res_d.entry_key = KEY_FIELD_W'(rd_data);
        res_d.occupied  = (rd_data != '0);
        res_d.hit       = 1'b0;
        done_d          = 1'b1;
        state_d         = ST_IDLE;
      end

      ST_SEARCH: begin
        if (match) begin
          // hit: newer entries move back one slot
          prev_d  = cmp_ptr_q;
          cur_d   = ring_next(cmp_ptr_q);
          pend_d  = 1'b0;
          state_d = ST_SHIFT;
        end else if ((scnt_q == DEPTH_CNT) && !cmp_v_q) begin
          // miss: overwrite the oldest slot
          acc.wr_en   = 1'b1;
          acc.wr_addr = head_q;
          acc.wr_data = key_q;
          head_d      = ring_next(head_q);
          res_d       = '0;
          done_d      = 1'b1;
          state_d     = ST_IDLE;
        end else if (scnt_q != DEPTH_CNT) begin
          acc.rd_en   = 1'b1;
          acc.rd_addr = rptr_q;
          rptr_d      = ring_next(rptr_q);
          scnt_d      = scnt_q + CNT_W'(1);
          cmp_v_d     = 1'b1;
          cmp_ptr_d   = rptr_q;
        end
      end

      ST_SHIFT: begin
        // write back the entry read last cycle
        if (pend_q) begin
          acc.wr_en   = 1'b1;
          acc.wr_addr = wprev_q;
          acc.wr_data = rd_data;
        end
        if (cur_q != head_q) begin
          acc.rd_en   = 1'b1;
          acc.rd_addr = cur_q;
          pend_d      = 1'b1;
          wprev_d     = prev_q;
          prev_d      = cur_q;
          cur_d       = ring_next(cur_q);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          // key lands in the newest slot
          acc.wr_en   = 1'b1;
          acc.wr_addr = prev_q;
          acc.wr_data = key_q;
          res_d       = '0;
          res_d.hit   = 1'b1;
          done_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      scnt_q  <= '0;
      cmp_v_q <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      scnt_q  <= scnt_d;
      cmp_v_q <= cmp_v_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // request payload and pointers
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    key_q     <= key_d;
    age_q     <= age_d;
    rptr_q    <= rptr_d;
    cmp_ptr_q <= cmp_ptr_d;
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    wprev_q   <= wprev_d;
    res_q     <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // the store is written only while a request is at work, and only for adds
  a_write_in_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc.wr_en |-> (busy && (kind_q == KIND_ADD)))
    else $error("store written outside an add");

  // a result never claims both a hit and an occupied read
  a_res_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.hit && res_o.occupied))
    else $error("result with hit and occupied set");

  // results never come in two consecutive cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in a row");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// Testbench for the recent-key move-to-front ring: directed and random add/read requests,
// each result checked field by field against a recency predictor kept in the testbench.
// Depends on rkmtf_pkg and recent_key_move_to_front_ring_top.

module testbench;
  import rkmtf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 60;

  // one queued request, or a marker that holds the sender until the ring is quiet
  typedef struct packed {
    req_t       req;
    logic [7:0] gap;
    logic       drain;
  } pending_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  pending_t    pending_req_q[$];
  res_t        expected_res_q[$];
  key_t        ring_keys[DEPTH];
  int unsigned ring_head;
  logic        req_taken = 1'b0;
  int unsigned idle_left = 0;
  bit          no_idle   = 1'b0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  key_t        key_pool[$];

  recent_key_move_to_front_ring_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned ring_step(input int unsigned s);
    return (s + 1) % DEPTH;
  endfunction

  // recency ring: search oldest to newest, move to front on hit, evict oldest on miss
  function automatic res_t predict_recency(input req_t r);
    res_t        res;
    key_t        k;
    int unsigned s;
    int unsigned prev;
    int unsigned cur;
    int unsigned age_slot;
    bit          found;
    res   = '0;
    k     = key_t'(r.key);
    found = 1'b0;
    s     = ring_head;
    prev  = 0;
    if (r.kind == KIND_ADD) begin
      for (int n = 0; n < DEPTH; n++) begin
        if (!found && ring_keys[s] != '0 && ring_keys[s] == k) begin
          found = 1'b1;
          prev  = s;
        end
        s = ring_step(s);
      end
      if (found) begin
        res.hit = 1'b1;
        cur = ring_step(prev);
        while (cur != ring_head) begin
          ring_keys[prev] = ring_keys[cur];
          prev = cur;
          cur  = ring_step(cur);
        end
        ring_keys[prev] = k;
      end else begin
        ring_keys[ring_head] = k;
        ring_head = ring_step(ring_head);
      end
    end else if (r.age_index < DEPTH) begin
      age_slot = (ring_head + 2 * DEPTH - 1 - r.age_index) % DEPTH;
      res.entry_key = KEY_FIELD_W'(ring_keys[age_slot]);
      res.occupied  = (ring_keys[age_slot] != '0);
    end
    return res;
  endfunction

  function automatic logic [KEY_FIELD_W-1:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  // idle cycles after a request: mostly none or short, a few long
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_request(input logic kind, input logic [KEY_FIELD_W-1:0] key,
                                       input logic [AGE_W-1:0] age);
    pending_t p;
    p.req.kind      = kind;
    p.req.key       = key;
    p.req.age_index = age;
    p.gap           = 8'(random_gap());
    p.drain         = 1'b0;
    pending_req_q.push_back(p);
  endfunction

  function automatic void push_drain();
    pending_t p;
    p       = '0;
    p.drain = 1'b1;
    pending_req_q.push_back(p);
  endfunction

  // driver: present the next request at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    logic next_start;
    req_t next_req;
    next_start = start;
    next_req   = req_i;
    if (rst_ni) begin
      if (start && req_taken) begin
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (idle_left != 0) begin
          idle_left = idle_left - 1;
        end else if (pending_req_q.size() != 0) begin
          if (pending_req_q[0].drain) begin
            if (expected_res_q.size() == 0) begin
              void'(pending_req_q.pop_front());
            end
          end else begin
            next_req   = pending_req_q[0].req;
            idle_left  = pending_req_q[0].gap;
            next_start = 1'b1;
            void'(pending_req_q.pop_front());
          end
        end
      end
    end
    start <= next_start;
    req_i <= next_req;
  end

  // monitor: check each result strobe, predict each accepted request
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_res_q.size() == 0) begin
          $error("result with no request outstanding: entry_key %h occupied %b hit %b",
                 res_o.entry_key, res_o.occupied, res_o.hit);
          fail_count++;
        end else begin
          want = expected_res_q.pop_front();
          if (res_o.entry_key !== want.entry_key) begin
            $error("entry_key: expected %h, got %h", want.entry_key, res_o.entry_key);
            fail_count++;
          end
          if (res_o.occupied !== want.occupied) begin
            $error("occupied: expected %b, got %b", want.occupied, res_o.occupied);
            fail_count++;
          end
          if (res_o.hit !== want.hit) begin
            $error("hit: expected %b, got %b", want.hit, res_o.hit);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_res_q.push_back(predict_recency(req_i));
      end
    end
    req_taken <= rst_ni && start && !busy;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned pool_size;
    int unsigned r;
    for (int i = 0; i < DEPTH; i++) begin
      ring_keys[i] = '0;
    end
    ring_head = 0;

    // directed: empty ring, extreme keys, empty key, hits with and without a shift, wrap
    push_request(KIND_READ, '0, 4'd0);
    push_request(KIND_READ, '1, 4'd15);
    push_request(KIND_ADD, '1, 4'd15);
    push_request(KIND_ADD, 64'd1, 4'd0);
    push_request(KIND_ADD, '1, 4'd0);
    push_request(KIND_ADD, '1, 4'd7);
    push_request(KIND_ADD, '0, 4'd0);
    push_request(KIND_ADD, 64'h8000_0000_0000_0000, 4'd0);
    push_request(KIND_READ, 64'h5555_aaaa_5555_aaaa, 4'd0);
    push_request(KIND_READ, '0, 4'd1);
    for (int j = 2; j < 15; j++) begin
      push_request(KIND_ADD, {32'(j), 32'hdead_0000 | 32'(j)}, 4'(j));
    end
    push_request(KIND_READ, '0, 4'd15);
    push_request(KIND_READ, '0, 4'd0);
    push_drain();

    // random phases: small pool gives many hits, large pool many evictions
    for (int phase = 0; phase < 3; phase++) begin
      pool_size = (phase == 0) ? 10 : (phase == 1) ? 24 : 64;
      key_pool.delete();
      for (int j = 0; j < pool_size; j++) begin
        if ($urandom_range(0, 3) == 0) begin
          key_pool.push_back(key_t'($urandom_range(1, 40)));
        end else begin
          key_pool.push_back(key_t'(random_key() | 64'd1));
        end
      end
      for (int i = 0; i < 350; i++) begin
        if (i % 70 == 0) begin
          no_idle = ($urandom_range(0, 2) == 0);
        end
        r = $urandom_range(0, 99);
        if (r < 30) begin
          push_request(KIND_READ, random_key(), 4'($urandom_range(0, 15)));
        end else if (r < 33) begin
          push_request(KIND_ADD, '0, 4'($urandom_range(0, 15)));
        end else if (r < 40) begin
          push_request(KIND_ADD, random_key(), 4'($urandom_range(0, 15)));
        end else begin
          push_request(KIND_ADD, key_pool[$urandom_range(0, pool_size - 1)],
                       4'($urandom_range(0, 15)));
        end
      end
      push_drain();
    end

    // reset, released at a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_req_q.size() != 0 || start || expected_res_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
